// ===== rtl/swpn_pkg.sv =====
// ----------------------------------------------------------------------------
// swpn_pkg
// Shared types, constants and helpers for the stereo white/pink noise
// generator.
// ----------------------------------------------------------------------------
package swpn_pkg;

  localparam int PHASE_BITS = 8;
  localparam int BAND_COUNT = 8;
  localparam int PINK_SHIFT = 3;

  localparam int WHITE_W    = 31;
  localparam int SUM_W      = 32;
  localparam int BAND_W     = WHITE_W - PINK_SHIFT;
  localparam int BAND_IDX_W = $clog2(BAND_COUNT);
  localparam int MULT_W     = 16;
  localparam int PROD_W     = WHITE_W + MULT_W;

  localparam logic [MULT_W-1:0]  PM_MULT   = MULT_W'(48271);
  localparam logic [WHITE_W-1:0] SEED_INIT = WHITE_W'(1);

  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD1,
    ST_MUL2,
    ST_FOLD2,
    ST_HOLD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // capture the input item
    logic mul_en;      // register a generator product
    logic mul_src_nl;  // multiply the first new sample instead of the state
    logic nl_load;     // hold the first folded sample
    logic pink_upd;    // refresh one band per channel and advance the phase
    logic gen_load;    // store the second folded sample as generator state
    logic out_load;    // load the output register
  } cmd_t;

  // Band index: trailing-zero count of the phase, saturated; phase zero uses
  // band zero.
  function automatic logic [BAND_IDX_W-1:0] band_of(input logic [PHASE_BITS-1:0] ph);
    logic [BAND_IDX_W-1:0] b;
    b = BAND_IDX_W'(BAND_COUNT - 1);
    for (int i = BAND_COUNT - 2; i >= 0; i--) begin
      if (i < PHASE_BITS) begin
        if (ph[i]) begin
          b = BAND_IDX_W'(i);
        end
      end
    end
    if (ph == '0) begin
      b = '0;
    end
    return b;
  endfunction

endpackage

// ===== rtl/stereo_white_pink_noise_gen.sv =====
// ----------------------------------------------------------------------------
// stereo_white_pink_noise_gen
// Stereo white and pink noise generator: two chained Park-Miller steps give
// the white samples, an octave band sum per channel gives the pink samples.
// ----------------------------------------------------------------------------
// Sequence: multiply on accept, then FOLD1, MUL2 and FOLD2 (multiply, fold,
//   multiply, fold) on the single shared 31x16 multiplier; the result loads
//   leaving FOLD2, or from HOLD, and only then is a new item taken in IDLE.
// A result waiting on the output does not stop the next item being accepted.
// Reset: synchronous; phase, bands and sums clear, generator state loads 1.
module stereo_white_pink_noise_gen
  import swpn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [30:0] white_left_in, [61:31] white_right_in, [63:62] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [31:0] pink_left, [63:32] pink_right, [94:64] white_left,
  // [125:95] white_right, [127:126] zero
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                seed_we,
  input  logic [WHITE_W-1:0]  seed
);

  cmd_t               cmd;
  logic [SUM_W-1:0]   pink_left, pink_right;
  logic [WHITE_W-1:0] white_left, white_right;

  swpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  swpn_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .seed_we        (seed_we),
    .seed           (seed),
    .white_left_in  (s_tdata[WHITE_W-1:0]),
    .white_right_in (s_tdata[2*WHITE_W-1:WHITE_W]),
    .pink_left      (pink_left),
    .pink_right     (pink_right),
    .white_left     (white_left),
    .white_right    (white_right)
  );

  assign m_tdata = {2'b00, white_right, white_left, pink_right, pink_left};

endmodule

// ===== rtl/swpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// swpn_ctrl
// Sequencer for one sample tick and owner of the output handshake.
// ----------------------------------------------------------------------------
module swpn_ctrl
  import swpn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || m_tready;
  assign m_tvalid = out_valid;
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          cmd.mul_en = 1'b1;
          state_next = ST_FOLD1;
        end
      end
      ST_FOLD1: begin
        cmd.nl_load  = 1'b1;
        cmd.pink_upd = 1'b1;
        state_next   = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_src_nl = 1'b1;
        state_next     = ST_FOLD2;
      end
      ST_FOLD2: begin
        cmd.gen_load = 1'b1;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for the previous result to be taken
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("output loaded over an untaken item");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_FOLD1))
    else $error("accepted item did not start the sequence");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("result appeared without a load");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !cmd.accept)
    else $error("item accepted mid-sequence");

endmodule

// ===== rtl/swpn_dp.sv =====
// ----------------------------------------------------------------------------
// swpn_dp
// Datapath: pink band stores and running sums, shared generator multiplier
// with modulo 2^31-1 fold, and the output register.
// ----------------------------------------------------------------------------
module swpn_dp
  import swpn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic                seed_we,
  input  logic [WHITE_W-1:0]  seed,
  input  logic [WHITE_W-1:0]  white_left_in,
  input  logic [WHITE_W-1:0]  white_right_in,
  output logic [SUM_W-1:0]    pink_left,
  output logic [SUM_W-1:0]    pink_right,
  output logic [WHITE_W-1:0]  white_left,
  output logic [WHITE_W-1:0]  white_right
);

  logic [BAND_W-1:0]     left_bands  [BAND_COUNT];
  logic [BAND_W-1:0]     right_bands [BAND_COUNT];
  logic [SUM_W-1:0]      left_sum, right_sum;
  logic [SUM_W-1:0]      left_sum_next, right_sum_next;
  logic [PHASE_BITS-1:0] phase_count;
  logic [WHITE_W-1:0]    gen;
  logic [WHITE_W-1:0]    nl;
  logic [WHITE_W-1:0]    wl_in, wr_in;
  logic [PROD_W-1:0]     prod;
  logic [WHITE_W-1:0]    mul_a;
  logic [SUM_W-1:0]      fold1;
  logic [WHITE_W-1:0]    fold_val;
  logic [BAND_IDX_W-1:0] band;
  logic [BAND_W-1:0]     vl, vr;

  assign band  = band_of(phase_count);
  assign vl    = wl_in[WHITE_W-1:PINK_SHIFT];
  assign vr    = wr_in[WHITE_W-1:PINK_SHIFT];
  assign mul_a = cmd.mul_src_nl ? nl : gen;

  // x mod (2^31-1): add high part onto low part, twice
  assign fold1    = SUM_W'(prod[WHITE_W-1:0]) + SUM_W'(prod[PROD_W-1:WHITE_W]);
  assign fold_val = fold1[WHITE_W-1:0] + WHITE_W'(fold1[WHITE_W]);

  assign left_sum_next  = left_sum - SUM_W'(left_bands[band]) + SUM_W'(vl);
  assign right_sum_next = right_sum - SUM_W'(right_bands[band]) + SUM_W'(vr);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      gen         <= SEED_INIT;
      left_sum    <= '0;
      right_sum   <= '0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        left_bands[i]  <= '0;
        right_bands[i] <= '0;
      end
    end else begin
      if (seed_we) begin
        gen <= seed;
      end else if (cmd.gen_load) begin
        gen <= fold_val;
      end
      if (cmd.pink_upd) begin
        left_sum          <= left_sum_next;
        right_sum         <= right_sum_next;
        left_bands[band]  <= vl;
        right_bands[band] <= vr;
        phase_count       <= phase_count + PHASE_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wl_in <= white_left_in;
      wr_in <= white_right_in;
    end
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(PM_MULT);
    end
    if (cmd.nl_load) begin
      nl <= fold_val;
    end
    if (cmd.out_load) begin
      pink_left   <= left_sum;
      pink_right  <= right_sum;
      white_left  <= nl;
      // straight from the fold when loading in the same cycle as the state
      white_right <= cmd.gen_load ? fold_val : gen;
    end
  end

endmodule

// ===== tb/tb_stereo_white_pink_noise_gen.sv =====
// ----------------------------------------------------------------------------
// tb_stereo_white_pink_noise_gen
// Self-checking bench for the stereo white/pink noise generator. A short
// table of directed items and seed loads runs first, then several random
// phases, each opened by a fresh seed. Every accepted item is run through a
// behavioural predictor of the band sums and the Park-Miller generator, and
// each result leaving the block is compared field by field with the oldest
// predicted sample. Both stream sides stall at random, except in one phase.
// ----------------------------------------------------------------------------
module tb_stereo_white_pink_noise_gen;
  import swpn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [WHITE_W-1:0] WHITE_MAX   = '1;
  localparam int                 PHASE_ITEMS = 110;
  localparam int                 RAND_PHASES = 5;

  typedef struct {
    logic [SUM_W-1:0]   pink_l;
    logic [SUM_W-1:0]   pink_r;
    logic [WHITE_W-1:0] white_l;
    logic [WHITE_W-1:0] white_r;
  } noise_t;

  typedef enum logic {ROW_ITEM, ROW_SEED} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [WHITE_W-1:0] a;        // left white sample, or the seed
    logic [WHITE_W-1:0] b;        // right white sample
    logic               fix_white;
    logic               fix_pink;
    logic [SUM_W-1:0]   pink_l;
    logic [SUM_W-1:0]   pink_r;
    logic [WHITE_W-1:0] white_l;
    logic [WHITE_W-1:0] white_r;
  } dir_row_t;

  // Fixed values are given only where they follow at once: the first item
  // after reset, and the generator held at a degenerate seed or restarted.
  localparam int DIR_ROWS = 20;
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_ITEM, 31'h7fffffff, 31'h0,        1'b1, 1'b1, 32'h0fffffff, 32'h0,
      31'd48271, 31'd182605794},
    '{ROW_ITEM, 31'h0,        31'h7fffffff, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h2aaaaaaa, 31'h55555555, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h55555555, 31'h2aaaaaaa, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h1,        31'h7,        1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h8,        31'h7ffffff8, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h7fffffff, 31'h7fffffff, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_SEED, 31'h0,        31'h0,        1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h12345678, 31'h0edcba98, 1'b1, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h7fffffff, 31'h0,        1'b1, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_SEED, 31'h7fffffff, 31'h0,        1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h0,        31'h7fffffff, 1'b1, 1'b0, 32'h0, 32'h0,
      31'h7fffffff, 31'h7fffffff},
    '{ROW_ITEM, 31'h3c3c3c3c, 31'h43c3c3c3, 1'b1, 1'b0, 32'h0, 32'h0,
      31'h7fffffff, 31'h7fffffff},
    '{ROW_SEED, 31'h7ffffffe, 31'h0,        1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h00ff00ff, 31'h7f00ff00, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h7fffffff, 31'h7fffffff, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_SEED, 31'h1,        31'h0,        1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h7fffffff, 31'h7fffffff, 1'b1, 1'b0, 32'h0, 32'h0,
      31'd48271, 31'd182605794},
    '{ROW_ITEM, 31'h0,        31'h0,        1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0},
    '{ROW_ITEM, 31'h40000000, 31'h1,        1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 31'h0}
  };

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                seed_we  = 1'b0;
  logic [WHITE_W-1:0]  seed     = '0;

  // predictor state
  logic [PHASE_BITS-1:0] phase_q;
  logic [WHITE_W-1:0]    gen_q;
  logic [BAND_W-1:0]     bands_l [BAND_COUNT];
  logic [BAND_W-1:0]     bands_r [BAND_COUNT];
  logic [SUM_W-1:0]      sum_l;
  logic [SUM_W-1:0]      sum_r;

  noise_t pending_samples [$];
  int     mismatches = 0;
  bit     no_gaps    = 1'b0;

  stereo_white_pink_noise_gen uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .seed_we  (seed_we),
    .seed     (seed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  // times 48271 modulo 2^31-1, folded twice
  function automatic logic [WHITE_W-1:0] park_miller_step(input logic [WHITE_W-1:0] st);
    logic [63:0] prod;
    logic [32:0] x;
    prod = 64'(st) * 64'(PM_MULT);
    x    = 33'(prod[30:0]) + 33'(prod[63:31]);
    x    = 33'(x[30:0]) + 33'(x[32:31]);
    return x[30:0];
  endfunction

  // trailing zeros of the phase, saturated; phase zero takes band zero
  function automatic int band_for_phase(input logic [PHASE_BITS-1:0] ph);
    int tz;
    tz = 0;
    if (ph == '0) begin
      return 0;
    end
    while (!ph[tz]) begin
      tz++;
    end
    return (tz > BAND_COUNT - 1) ? BAND_COUNT - 1 : tz;
  endfunction

  task automatic compute_noise_sample(input logic [WHITE_W-1:0] wl, input logic [WHITE_W-1:0] wr,
                                      output noise_t r);
    int                band;
    logic [BAND_W-1:0] vl;
    logic [BAND_W-1:0] vr;
    band = band_for_phase(phase_q);
    vl = BAND_W'(wl >> PINK_SHIFT);
    vr = BAND_W'(wr >> PINK_SHIFT);
    sum_l = sum_l - SUM_W'(bands_l[band]) + SUM_W'(vl);
    sum_r = sum_r - SUM_W'(bands_r[band]) + SUM_W'(vr);
    bands_l[band] = vl;
    bands_r[band] = vr;
    phase_q = phase_q + 1'b1;
    r.pink_l  = sum_l;
    r.pink_r  = sum_r;
    r.white_l = park_miller_step(gen_q);
    r.white_r = park_miller_step(r.white_l);
    gen_q = r.white_r;
  endtask

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                 input logic [SUM_W-1:0] want);
    $display("[%0t] %s: got %h, wanted %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Drive one item, hold until accepted, return the predicted sample.
  task automatic send_item(input logic [WHITE_W-1:0] wl, input logic [WHITE_W-1:0] wr,
                           output noise_t r);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < 24) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, wr, wl};
    do @(posedge clk); while (!s_tready);
    compute_noise_sample(wl, wr, r);
  endtask

  // Load a seed once every pending sample has come out.
  task automatic load_seed(input logic [WHITE_W-1:0] v);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_samples.size() != 0) begin
      @(negedge clk);
    end
    seed_we = 1'b1;
    seed    = v;
    @(negedge clk);
    seed_we = 1'b0;
    gen_q   = v;
  endtask

  function automatic logic [WHITE_W-1:0] rand_white();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WHITE_MAX;
      2:       return WHITE_W'($urandom_range(0, 15));
      default: return WHITE_W'($urandom);
    endcase
  endfunction

  always @(negedge clk) begin
    m_tready <= no_gaps || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    noise_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected sample", m_tdata[31:0], '0);
      end else begin
        want = pending_samples.pop_front();
        if (m_tdata[31:0] !== want.pink_l)
          report_mismatch("pink_left", m_tdata[31:0], want.pink_l);
        if (m_tdata[63:32] !== want.pink_r)
          report_mismatch("pink_right", m_tdata[63:32], want.pink_r);
        if (m_tdata[94:64] !== want.white_l)
          report_mismatch("white_left", SUM_W'(m_tdata[94:64]), SUM_W'(want.white_l));
        if (m_tdata[125:95] !== want.white_r)
          report_mismatch("white_right", SUM_W'(m_tdata[125:95]), SUM_W'(want.white_r));
      end
    end
  end

  initial begin
    noise_t r;
    int     drain;
    phase_q = '0;
    gen_q   = SEED_INIT;
    sum_l   = '0;
    sum_r   = '0;
    for (int i = 0; i < BAND_COUNT; i++) begin
      bands_l[i] = '0;
      bands_r[i] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SEED) begin
        load_seed(directed_rows[i].a);
      end else begin
        send_item(directed_rows[i].a, directed_rows[i].b, r);
        if (directed_rows[i].fix_white) begin
          r.white_l = directed_rows[i].white_l;
          r.white_r = directed_rows[i].white_r;
        end
        if (directed_rows[i].fix_pink) begin
          r.pink_l = directed_rows[i].pink_l;
          r.pink_r = directed_rows[i].pink_r;
        end
        pending_samples.push_back(r);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      // one phase runs with both sides flat out
      no_gaps = (p == 2);
      load_seed(WHITE_W'($urandom_range(1, 32'h7ffffffe)));
      repeat (PHASE_ITEMS) begin
        send_item(rand_white(), rand_white(), r);
        pending_samples.push_back(r);
      end
    end
    no_gaps = 1'b0;

    @(negedge clk);
    s_tvalid = 1'b0;
    drain = 0;
    while (pending_samples.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending_samples.size() != 0) begin
      report_mismatch("samples never delivered", SUM_W'(pending_samples.size()), '0);
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swpn_pkg.sv
rtl/swpn_ctrl.sv
rtl/swpn_dp.sv
rtl/stereo_white_pink_noise_gen.sv
tb/tb_stereo_white_pink_noise_gen.sv
